@@ rtl/cfae_pkg.sv @@
// Shared constants and types for the complex float approximate-equal comparator.
// No dependencies; used by cfae_part and complex_float_approx_equal.
`default_nettype none
package cfae_pkg;

    localparam int NSTG = 5;                       // pipeline register stages

    // 1E-6 as a double: significand C with value C * 2^-72.
    localparam logic [52:0] TOL_MANT = 53'h10C6F7A0B5ED8D;
    localparam logic [31:0] TOL_LO   = TOL_MANT[31:0];
    localparam logic [20:0] TOL_HI   = TOL_MANT[52:32];

    typedef logic signed [9:0] exp_t;              // unbiased binary exponent
    typedef logic [NSTG-1:0]   stg_en_t;           // per-stage load enables

endpackage
`default_nettype wire

@@ rtl/cfae_part.sv @@
// One part (real or imaginary) of the approximate compare: five-stage pipeline.
// Depends on cfae_pkg.
`default_nettype none
module cfae_part
    import cfae_pkg::*;
(
    input  wire logic        clk,
    input  wire stg_en_t     en,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic             match
);

    // ---------------- stage 1: classify, order by magnitude ----------------
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic        spec_c, smatch_c, a_ge;
    logic [31:0] lg, sm;
    logic [7:0]  el_c, es_c;

    always_comb
    begin
        a_nan  = a[30:0] > 31'h7F800000;
        b_nan  = b[30:0] > 31'h7F800000;
        a_inf  = a[30:0] == 31'h7F800000;
        b_inf  = b[30:0] == 31'h7F800000;
        a_zero = a[30:0] == 31'd0;
        b_zero = b[30:0] == 31'd0;
        spec_c = a_nan | b_nan | a_inf | b_inf | a_zero | b_zero;
        if (a_nan || b_nan)
            smatch_c = a_nan & b_nan;
        else if (a_inf || b_inf)
            smatch_c = a_inf & b_inf & (a[31] == b[31]);
        else
            smatch_c = a_zero & b_zero & (a[31] == b[31]);
        a_ge = a[30:0] >= b[30:0];
        lg   = a_ge ? a : b;
        sm   = a_ge ? b : a;
        el_c = (lg[30:23] == 8'd0) ? 8'd1 : lg[30:23];
        es_c = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
    end

    logic        s1_spec_reg, s1_smatch_reg, s1_sub_reg;
    logic [7:0]  s1_el_reg, s1_sh_reg;
    logic [23:0] s1_ml_reg, s1_ms_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_spec_reg   <= spec_c;
            s1_smatch_reg <= smatch_c;
            s1_sub_reg    <= a[31] == b[31];     // a - b subtracts magnitudes
            s1_el_reg     <= el_c;
            s1_sh_reg     <= el_c - es_c;
            s1_ml_reg     <= {lg[30:23] != 8'd0, lg[22:0]};
            s1_ms_reg     <= {sm[30:23] != 8'd0, sm[22:0]};
        end
    end

    // ---------------- stage 2: align, add or subtract; normalize the larger value
    logic [26:0] ms_ext, ms_sh, lost;
    logic [26:0] aligned;
    logic [27:0] r_c;
    logic [4:0]  lzm;
    logic [23:0] nm_c;
    exp_t        km_c;

    always_comb
    begin
        ms_ext = {s1_ms_reg, 3'b000};
        if (s1_sh_reg >= 8'd27)
        begin
            ms_sh = 27'd0;
            lost  = ms_ext;
        end
        else
        begin
            ms_sh = ms_ext >> s1_sh_reg;
            lost  = ms_ext & ~({27{1'b1}} << s1_sh_reg);
        end
        aligned = {ms_sh[26:1], ms_sh[0] | (|lost)};
        if (s1_sub_reg)
            r_c = {1'b0, s1_ml_reg, 3'b000} - {1'b0, aligned};
        else
            r_c = {1'b0, s1_ml_reg, 3'b000} + {1'b0, aligned};
        lzm = 5'd0;
        for (int i = 0; i < 24; i++)
        begin
            if (s1_ml_reg[i])
                lzm = 5'(23 - i);
        end
        nm_c = s1_ml_reg << lzm;
        km_c = $signed({2'b00, s1_el_reg}) - 10'sd150 - $signed({5'b00000, lzm});
    end

    logic        s2_spec_reg, s2_smatch_reg;
    logic [7:0]  s2_el_reg;
    logic [27:0] s2_r_reg;
    logic [23:0] s2_nm_reg;
    exp_t        s2_km_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_spec_reg   <= s1_spec_reg;
            s2_smatch_reg <= s1_smatch_reg;
            s2_el_reg     <= s1_el_reg;
            s2_r_reg      <= r_c;
            s2_nm_reg     <= nm_c;
            s2_km_reg     <= km_c;
        end
    end

    // ---------------- stage 3: normalize difference; partial products -------
    logic [4:0]  lz;
    logic [27:0] rn_c;

    always_comb
    begin
        lz = 5'd0;
        for (int i = 0; i < 28; i++)
        begin
            if (s2_r_reg[i])
                lz = 5'(27 - i);
        end
        rn_c = s2_r_reg << lz;
    end

    logic        s3_spec_reg, s3_smatch_reg, s3_rzero_reg;
    logic [7:0]  s3_el_reg;
    logic [27:0] s3_rn_reg;
    logic [4:0]  s3_lz_reg;
    logic [55:0] s3_pplo_reg;
    logic [44:0] s3_pphi_reg;
    exp_t        s3_km_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_spec_reg   <= s2_spec_reg;
            s3_smatch_reg <= s2_smatch_reg;
            s3_rzero_reg  <= s2_r_reg == 28'd0;
            s3_el_reg     <= s2_el_reg;
            s3_rn_reg     <= rn_c;
            s3_lz_reg     <= lz;
            s3_pplo_reg   <= {32'd0, s2_nm_reg} * {24'd0, TOL_LO};
            s3_pphi_reg   <= {21'd0, s2_nm_reg} * {24'd0, TOL_HI};
            s3_km_reg     <= s2_km_reg;
        end
    end

    // ---------------- stage 4: round difference to single; sum product ------
    logic [24:0] rsum;
    logic        rup;
    logic [23:0] nd_c;
    exp_t        kd_c;
    logic [76:0] q, qn_c;
    exp_t        eq_c;

    always_comb
    begin
        rup  = s3_rn_reg[3] & ((|s3_rn_reg[2:0]) | s3_rn_reg[4]);
        rsum = {1'b0, s3_rn_reg[27:4]} + {24'd0, rup};
        nd_c = rsum[24] ? 24'h800000 : rsum[23:0];
        kd_c = $signed({2'b00, s3_el_reg}) - 10'sd149 - $signed({5'b00000, s3_lz_reg})
             + $signed({9'd0, rsum[24]});
        q    = {s3_pphi_reg, 32'd0} + {21'd0, s3_pplo_reg};
        qn_c = q[76] ? q : (q << 1);
        eq_c = q[76] ? (s3_km_reg - 10'sd72) : (s3_km_reg - 10'sd73);
    end

    logic        s4_spec_reg, s4_smatch_reg, s4_rzero_reg, s4_ovf_reg;
    logic [23:0] s4_nd_reg;
    exp_t        s4_kd_reg, s4_eq_reg;
    logic [76:0] s4_qn_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s4_spec_reg   <= s3_spec_reg;
            s4_smatch_reg <= s3_smatch_reg;
            s4_rzero_reg  <= s3_rzero_reg;
            s4_ovf_reg    <= kd_c > 10'sd104;     // rounded to infinity
            s4_nd_reg     <= nd_c;
            s4_kd_reg     <= kd_c;
            s4_qn_reg     <= qn_c;
            s4_eq_reg     <= eq_c;
        end
    end

    // ---------------- stage 5: compare tol*max against |d| + half double ulp -
    // |d| < round64(tol*max) exactly when tol*max > |d| + ulp64(|d|)/2.
    logic [76:0] dn;
    exp_t        ed;
    logic        gt, match_c;

    always_comb
    begin
        dn = {s4_nd_reg, 29'd0, 1'b1, 23'd0};
        ed = s4_kd_reg - 10'sd53;
        gt = (s4_eq_reg > ed) || ((s4_eq_reg == ed) && (s4_qn_reg > dn));
        if (s4_spec_reg)
            match_c = s4_smatch_reg;
        else if (s4_rzero_reg)
            match_c = 1'b1;
        else if (s4_ovf_reg)
            match_c = 1'b0;
        else
            match_c = gt;
    end

    logic match_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
            match_reg <= match_c;
    end

    assign match = match_reg;

endmodule
`default_nettype wire

@@ rtl/complex_float_approx_equal.sv @@
// Top level of the complex single-precision approximate-equal comparator.
// Depends on cfae_pkg and cfae_part.
//
// Compares two complex numbers given as IEEE-754 single bit patterns, real
// against real and imaginary against imaginary. A part matches when both are
// NaN, both are infinite with equal sign, both are zero with equal sign, or
// otherwise when |x-y| rounded to single is below 1E-6*max(|x|,|y|) formed in
// double. Subnormals are kept exact. The result is registered through each
// pipeline stage after the request is accepted. A new request can be taken
// every cycle unless a stalled output has filled the five-stage compare
// pipeline (subtract, normalize, round, 53x24 product split in two
// multipliers). Each stage holds its own valid bit, so a stalled output only
// backs up the stages behind a full one; empty stages keep accepting.
`default_nettype none
module complex_float_approx_equal
    import cfae_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [31:0] x_real, [63:32] x_imag, [95:64] y_real, [127:96] y_imag
    input  wire logic [127:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [0] equal, [1] real_match, [2] imag_match, [7:3] zero
    output logic [7:0]        m_axis_tdata
);

    stg_en_t          en;
    logic [NSTG-1:0]  vld_reg, vld_next;
    logic             real_match, imag_match;

    // a stage loads when it is empty or its contents move on
    always_comb
    begin
        en[NSTG-1] = ~vld_reg[NSTG-1] | m_axis_tready;
        for (int i = NSTG - 2; i >= 0; i--)
            en[i] = ~vld_reg[i] | en[i+1];
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (en[0])
            vld_next[0] = s_axis_tvalid;
        for (int i = 1; i < NSTG; i++)
        begin
            if (en[i])
                vld_next[i] = vld_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    cfae_part u_real
    (
        .clk   (clk),
        .en    (en),
        .a     (s_axis_tdata[31:0]),
        .b     (s_axis_tdata[95:64]),
        .match (real_match)
    );

    cfae_part u_imag
    (
        .clk   (clk),
        .en    (en),
        .a     (s_axis_tdata[63:32]),
        .b     (s_axis_tdata[127:96]),
        .match (imag_match)
    );

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = vld_reg[NSTG-1];
    assign m_axis_tdata  = {5'd0, imag_match, real_match, real_match & imag_match};

endmodule
`default_nettype wire

@@ dv/tb_complex_float_approx_equal.sv @@
// Testbench for complex_float_approx_equal: random and directed complex pairs
// are streamed in and each verdict is checked against an exact-arithmetic predictor.
// Depends on rtl/cfae_pkg.sv, rtl/cfae_part.sv and rtl/complex_float_approx_equal.sv.
`default_nettype none
module tb_complex_float_approx_equal;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 12;   // margin for the pipeline to drain
    localparam int CALM_TAIL    = 80;   // final requests sent with no idling

    typedef struct packed {
        logic [31:0] yi;
        logic [31:0] yr;
        logic [31:0] xi;
        logic [31:0] xr;
    } cplx_pair_t;

    typedef struct packed {
        logic imag_match;
        logic real_match;
        logic equal;
    } verdict_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;

    cplx_pair_t pending_pairs[$];
    verdict_t   expected_verdicts[$];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    int         send_gap = 0;
    int         sink_stall = 0;

    complex_float_approx_equal i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    // Value of a single as mantissa * 2^exp, subnormals kept exact.
    function automatic void split_single(input logic [31:0] b, output logic [23:0] mant,
                                         output int exp2);
        if (b[30:23] == 8'd0)
        begin
            mant = {1'b0, b[22:0]};
            exp2 = -149;
        end
        else
        begin
            mant = {1'b1, b[22:0]};
            exp2 = int'(b[30:23]) - 150;
        end
    endfunction

    // Part rule: NaN, then infinity, then zero, then relative tolerance.
    // The difference is formed exactly, rounded to single (nearest even),
    // and compared in double against 1E-6 * max magnitude.
    function automatic logic parts_agree(input logic [31:0] a, input logic [31:0] b);
        logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, same_sign;
        logic [23:0] ma, mb;
        int          ea, eb, msb, sh;
        logic [287:0] va, vb, d, rem, half;
        longint      rmant;
        real         diff_r, big_r, tol_r;
        a_nan  = a[30:0] > 31'h7F80_0000;
        b_nan  = b[30:0] > 31'h7F80_0000;
        a_inf  = a[30:0] == 31'h7F80_0000;
        b_inf  = b[30:0] == 31'h7F80_0000;
        a_zero = a[30:0] == 31'd0;
        b_zero = b[30:0] == 31'd0;
        same_sign = a[31] == b[31];
        if (a_nan || b_nan)
            return a_nan && b_nan;
        if (a_inf || b_inf)
            return a_inf && b_inf && same_sign;
        if (a_zero || b_zero)
            return a_zero && b_zero && same_sign;
        split_single(a, ma, ea);
        split_single(b, mb, eb);
        va = 288'(ma) << (ea + 149);
        vb = 288'(mb) << (eb + 149);
        if (!same_sign)
            d = va + vb;
        else
            d = (va > vb) ? va - vb : vb - va;
        msb = -1;
        for (int i = 0; i < 288; i++)
            if (d[i])
                msb = i;
        if (msb <= 23)
        begin
            rmant = longint'(d[23:0]);
            sh = 0;
        end
        else
        begin
            sh = msb - 23;
            rem = d & ((288'(1) << sh) - 288'(1));
            half = 288'(1) << (sh - 1);
            d = d >> sh;
            rmant = longint'(d[24:0]);
            if (rem > half || (rem == half && rmant[0]))
                rmant++;
        end
        diff_r = real'(rmant) * (2.0 ** (sh - 149));
        // rounded difference at or past 2^128 means overflow to infinity
        if (diff_r >= 2.0 ** 128)
            return 1'b0;
        split_single((a[30:0] > b[30:0]) ? {1'b0, a[30:0]} : {1'b0, b[30:0]}, ma, ea);
        big_r = real'(ma) * (2.0 ** ea);
        tol_r = 1.0e-6 * big_r;
        return diff_r < tol_r;
    endfunction

    function automatic verdict_t predict_verdict(input cplx_pair_t p);
        verdict_t v;
        v.real_match = parts_agree(p.xr, p.yr);
        v.imag_match = parts_agree(p.xi, p.yi);
        v.equal      = v.real_match && v.imag_match;
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH %s at cycle %0d", msg, cycle_count);
        mismatch_count++;
    endtask

    // Random single: mostly normals, with specials and subnormals mixed in.
    function automatic logic [31:0] rand_single();
        case ($urandom_range(0, 9))
            0: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(0, 3) == 0 ?
                       0 : $urandom)};
            1: return {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom_range(0, 3) == 0 ?
                       0 : $urandom)};
            2: return $urandom;
            default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(1, 254)),
                             23'($urandom)};
        endcase
    endfunction

    // Partner near the first value: equal, negated, or up to 20 ulps off, around the tolerance edge.
    function automatic logic [31:0] near_single(input logic [31:0] a);
        int off;
        case ($urandom_range(0, 5))
            0: return a;
            1: return a ^ 32'h8000_0000;
            default:
            begin
                off = $urandom_range(0, 40) - 20;
                return a + 32'(off);
            end
        endcase
    endfunction

    function automatic cplx_pair_t rand_pair();
        cplx_pair_t p;
        p.xr = rand_single();
        p.xi = rand_single();
        p.yr = ($urandom_range(0, 3) == 0) ? rand_single() : near_single(p.xr);
        p.yi = ($urandom_range(0, 3) == 0) ? rand_single() : near_single(p.xi);
        if ($urandom_range(0, 15) == 0)
        begin
            p.xi = 32'd0;   // real-only use
            p.yi = 32'd0;
        end
        return p;
    endfunction

    // Driver: holds a request until it is taken, then picks the next one or idles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                expected_verdicts.push_back(predict_verdict(cplx_pair_t'(s_axis_tdata)));
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_pairs.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
            begin
                send_gap <= $urandom_range(0, 13);
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_pairs.size() > 0)
            begin
                s_axis_tdata <= pending_pairs.pop_front();
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Sink: random stall bursts, steady ready once the tail is reached.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_stall <= 0;
        end
        else if (sink_stall > 0)
        begin
            sink_stall <= sink_stall - 1;
            m_axis_tready <= 1'b0;
        end
        else if (pending_pairs.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
        begin
            sink_stall <= $urandom_range(0, 13);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Monitor: each accepted verdict against the oldest prediction.
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_verdicts.size() == 0)
                report_mismatch("unexpected verdict");
            else
            begin
                want = expected_verdicts.pop_front();
                if (m_axis_tdata[0] !== want.equal)
                    report_mismatch($sformatf("equal: got %0b want %0b",
                                              m_axis_tdata[0], want.equal));
                if (m_axis_tdata[1] !== want.real_match)
                    report_mismatch($sformatf("real_match: got %0b want %0b",
                                              m_axis_tdata[1], want.real_match));
                if (m_axis_tdata[2] !== want.imag_match)
                    report_mismatch($sformatf("imag_match: got %0b want %0b",
                                              m_axis_tdata[2], want.imag_match));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        cplx_pair_t p;
        // directed: specials, extremes, tolerance edge, overflow, subnormals
        pending_pairs.push_back('{32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001, 32'h7FC0_0000});
        pending_pairs.push_back('{32'h7F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h7F80_0000});
        pending_pairs.push_back('{32'hFF80_0000, 32'h7F80_0000, 32'hFF80_0000, 32'hFF80_0000});
        pending_pairs.push_back('{32'h7F80_0000, 32'h7F80_0000, 32'h7FC0_0000, 32'h7F7F_FFFF});
        pending_pairs.push_back('{32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000});
        pending_pairs.push_back('{32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000});
        pending_pairs.push_back('{32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001});
        pending_pairs.push_back('{32'h0000_0000, 32'h0000_0002, 32'h0000_0000, 32'h0000_0001});
        pending_pairs.push_back('{32'h0000_0000, 32'h0000_0000, 32'h807F_FFFF, 32'h007F_FFFF});
        pending_pairs.push_back('{32'h0000_0000, 32'h0000_0000, 32'hFF7F_FFFF, 32'h7F7F_FFFF});
        pending_pairs.push_back('{32'h0000_0000, 32'h0000_0000, 32'h7F7F_FFFF, 32'h7F7F_FFFE});
        pending_pairs.push_back('{32'h3F80_0008, 32'h3F80_0000, 32'h3F80_0009, 32'h3F80_0000});
        pending_pairs.push_back('{32'h3F7F_FFF0, 32'h3F80_0000, 32'h3F80_0011, 32'h3F80_0000});
        pending_pairs.push_back('{32'h0080_0000, 32'h0000_0000, 32'h3F80_0000, 32'h3380_0000});
        pending_pairs.push_back('{32'hBF80_0000, 32'h3F80_0000, 32'hC000_0000, 32'hC000_0001});
        pending_pairs.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        for (int i = 0; i < 750; i++)
        begin
            p = rand_pair();
            pending_pairs.push_back(p);
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_pairs.size() > 0 || s_axis_tvalid || expected_verdicts.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire
